### design/pwdm_pkg.sv
package pwdm_pkg;

    // capture counter width used when the top level is not overridden
    localparam int CAPTURE_BITS_DEF = 16;

    localparam int WIDTH_W   = 32;
    localparam int FREQ_W    = 40;
    localparam int DUTY_W    = 15;
    localparam int CFG_W     = 24;
    localparam int FRAC_BITS = 16;
    // high width times the full-scale duty
    localparam int PROD_W    = WIDTH_W + DUTY_W;

    localparam logic [CFG_W-1:0]  COUNT_FREQ_RESET = 24'd1000;
    // 100 percent in Q7.8
    localparam logic [DUTY_W-1:0] DUTY_FULL        = 15'd25600;

    localparam int FIFO_DEPTH = 2;

    // output word: high, low, period, frequency, duty, zero fill to whole bytes
    localparam int OUT_USED_W = 3 * WIDTH_W + FREQ_W + DUTY_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic [WIDTH_W-1:0] high;
        logic [WIDTH_W-1:0] low;
        logic [WIDTH_W-1:0] period;
    } widths_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREQ,
        ST_DUTY,
        ST_OUT
    } back_state_t;

endpackage

### design/pwdm_front.sv
module pwdm_front #(
    parameter int CAPTURE_BITS = pwdm_pkg::CAPTURE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [CAPTURE_BITS-1:0] capture_count,
    input  logic                    pin_read,
    output pwdm_pkg::widths_t       entry
);
    import pwdm_pkg::*;

    logic [WIDTH_W-1:0] prev_reg;
    logic [WIDTH_W-1:0] high_reg;
    logic [WIDTH_W-1:0] low_reg;
    logic [WIDTH_W-1:0] cur;
    logic [WIDTH_W-1:0] diff;
    logic [WIDTH_W-1:0] high_next;
    logic [WIDTH_W-1:0] low_next;

    // +1 covers the input sync latency
    always_comb
    begin
        cur       = WIDTH_W'(capture_count) + WIDTH_W'(1);
        diff      = cur - prev_reg;
        high_next = pin_read ? diff : high_reg;
        low_next  = pin_read ? low_reg : diff;
        entry.high   = high_next;
        entry.low    = low_next;
        entry.period = high_next + low_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            high_reg <= '0;
            low_reg  <= '0;
        end
        else if (accept)
        begin
            prev_reg <= cur;
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

endmodule

### design/pwdm_fifo.sv
module pwdm_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pwdm_pkg::widths_t      wr_entry,
    input  logic                   pop,
    output pwdm_pkg::widths_t      rd_entry,
    output pwdm_pkg::fifo_status_t status
);
    import pwdm_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    widths_t          mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_entry     = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

### design/pwdm_back.sv
module pwdm_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pwdm_pkg::CFG_W-1:0]          count_freq,
    input  pwdm_pkg::fifo_status_t              status,
    input  pwdm_pkg::widths_t                   head,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pwdm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser
);
    import pwdm_pkg::*;

    localparam int STEP_W = $clog2(FREQ_W);
    localparam logic [STEP_W-1:0] FREQ_LAST = STEP_W'(FREQ_W - 1);
    localparam logic [STEP_W-1:0] DUTY_LAST = STEP_W'(DUTY_W - 1);
    localparam int PAD_W = OUT_DATA_W - OUT_USED_W;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [STEP_W-1:0]    step_reg;
    widths_t              item_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_calc;
    logic [WIDTH_W-1:0]   rem_reg;
    logic [FREQ_W-1:0]    nq_reg;
    logic [FREQ_W-1:0]    freq_reg;
    logic [DUTY_W-1:0]    duty_reg;
    logic                 m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 out_load;
    logic                 duty_sat;

    // shared restoring divider step: remainder stays below the divisor
    logic [WIDTH_W:0]     r_shift;
    logic [WIDTH_W:0]     r_diff;
    logic                 q_bit;
    logic [WIDTH_W-1:0]   rem_step;
    logic [FREQ_W-1:0]    nq_step;

    always_comb
    begin
        r_shift  = {rem_reg, nq_reg[FREQ_W-1]};
        r_diff   = r_shift - {1'b0, item_reg.period};
        q_bit    = (r_shift >= {1'b0, item_reg.period});
        rem_step = q_bit ? r_diff[WIDTH_W-1:0] : r_shift[WIDTH_W-1:0];
        nq_step  = {nq_reg[FREQ_W-2:0], q_bit};
    end

    assign prod_calc = PROD_W'(head.high) * PROD_W'(DUTY_FULL);
    // high >= period forces quotient >= full scale
    assign duty_sat  = (item_reg.high >= item_reg.period);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!status.empty)
                    state_next = (head.period != '0) ? ST_FREQ : ST_OUT;
            end
            ST_FREQ:
            begin
                if (step_reg == FREQ_LAST)
                    state_next = duty_sat ? ST_OUT : ST_DUTY;
            end
            ST_DUTY:
            begin
                if (step_reg == DUTY_LAST)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pop      = (state_reg == ST_IDLE) && !status.empty;
        out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
            prod_reg <= prod_calc;
            rem_reg  <= '0;
            nq_reg   <= {count_freq, FRAC_BITS'(0)};
            step_reg <= '0;
        end
        else if (state_reg == ST_FREQ && step_reg == FREQ_LAST && !duty_sat)
        begin
            // reload for duty: top of the product is already below the period
            rem_reg  <= prod_reg[PROD_W-1:DUTY_W];
            nq_reg   <= {prod_reg[DUTY_W-1:0], (FREQ_W - DUTY_W)'(0)};
            step_reg <= '0;
        end
        else if (state_reg == ST_FREQ || state_reg == ST_DUTY)
        begin
            rem_reg  <= rem_step;
            nq_reg   <= nq_step;
            step_reg <= step_reg + STEP_W'(1);
        end
        if (out_load)
        begin
            m_tdata_reg <= {PAD_W'(0), duty_reg, freq_reg,
                            item_reg.period, item_reg.low, item_reg.high};
            m_tuser_reg <= (item_reg.period != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            freq_reg     <= '0;
            duty_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FREQ && step_reg == FREQ_LAST)
            begin
                freq_reg <= nq_step;
                if (duty_sat)
                    duty_reg <= DUTY_FULL;
            end
            if (state_reg == ST_DUTY && step_reg == DUTY_LAST)
                duty_reg <= nq_step[DUTY_W-1:0];
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### design/pulse_width_duty_meter.sv
// Pulse width / duty meter.
// Input stream (s_*): one word per capture event. s_tdata carries the captured
// timer count, s_tuser the pin level read after the edge (0: the interval that
// just ended was low, 1: it was high).
// Output stream (m_*): one word per input word with high width, low width,
// period, frequency (Q24.16 Hz) and duty (Q7.8 percent); m_tuser flags that the
// period was nonzero and frequency/duty were recomputed. A zero period repeats
// the last frequency and duty.
// Config channel (cfg_*): timer count frequency in Hz, always ready; write it
// only while the block is idle.
// Timing: the front end updates the widths in the accept cycle and queues them
// (two-entry queue). The back end runs one shared restoring divider, one
// quotient bit per cycle: 40 steps for frequency, then 15 for duty. A zero
// period skips the divider and a saturated duty skips the duty steps; the back
// end takes one item at a time. The output register holds a word while
// m_tready is low; the queue keeps taking input until it is full.
// Reset: widths, previous capture, stored frequency/duty cleared, count
// frequency back to 1000 Hz, output invalid.
module pulse_width_duty_meter #(
    parameter int CAPTURE_BITS = pwdm_pkg::CAPTURE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [CAPTURE_BITS-1:0] capture_count, rest zero fill
    input  logic [((CAPTURE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // [0] pin_read
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] high_len, [63:32] low_len, [95:64] period_counts,
    // [135:96] frequency_q16, [150:136] duty_q8, [151] zero
    output logic [pwdm_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [0] period_valid
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pwdm_pkg::CFG_W-1:0]           cfg_data
);
    import pwdm_pkg::*;

    logic [CFG_W-1:0] count_freq_reg;
    logic             accept;
    logic             pop;
    widths_t          front_entry;
    widths_t          head;
    fifo_status_t     status;

    // timer count frequency register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_freq_reg <= COUNT_FREQ_RESET;
        else if (cfg_valid && cfg_ready)
            count_freq_reg <= cfg_data;
    end

    // front end takes a word whenever the queue has room
    assign s_tready = !status.full;
    assign accept   = s_tvalid && s_tready;

    pwdm_front #(
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .capture_count (s_tdata[CAPTURE_BITS-1:0]),
        .pin_read      (s_tuser),
        .entry         (front_entry)
    );

    pwdm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .wr_entry (front_entry),
        .pop      (pop),
        .rd_entry (head),
        .status   (status)
    );

    // back end: divider and output register
    pwdm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .count_freq (count_freq_reg),
        .status     (status),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### design/pwdm_checker.sv
module pwdm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pwdm_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import pwdm_pkg::*;

    logic [WIDTH_W-1:0] high_f;
    logic [WIDTH_W-1:0] low_f;
    logic [WIDTH_W-1:0] period_f;
    logic [DUTY_W-1:0]  duty_f;

    assign high_f   = m_tdata[WIDTH_W-1:0];
    assign low_f    = m_tdata[2*WIDTH_W-1:WIDTH_W];
    assign period_f = m_tdata[3*WIDTH_W-1:2*WIDTH_W];
    assign duty_f   = m_tdata[OUT_USED_W-1:3*WIDTH_W+FREQ_W];

    a_period_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> period_f == WIDTH_W'(high_f + low_f))
        else $error("period is not high plus low");

    a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == (period_f != '0))
        else $error("period_valid disagrees with period");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> duty_f <= DUTY_FULL)
        else $error("duty above full scale");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

endmodule

bind pulse_width_duty_meter pwdm_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/tb_pulse_width_duty_meter.sv
`timescale 1ns / 1ps

module tb_pulse_width_duty_meter;
    import pwdm_pkg::*;

    localparam int CAP_W        = CAPTURE_BITS_DEF;
    localparam int CAP_DATA_W   = ((CAP_W + 7) / 8) * 8;
    localparam int RESET_CYCLES = 11;
    // settle time after the last due word: room for one item still in flight
    localparam int SETTLE_CYCLES = 80;
    // cycles with no word moving on any channel before giving up
    localparam int QUIET_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 100;
    localparam int ITEMS_PER_PHASE = 370;

    localparam logic [CFG_W-1:0] COUNT_FREQ_MAX = 24'd16000000;

    // output word layout, lowest bit first
    localparam int HIGH_LSB   = 0;
    localparam int LOW_LSB    = WIDTH_W;
    localparam int PERIOD_LSB = 2 * WIDTH_W;
    localparam int FREQ_LSB   = 3 * WIDTH_W;
    localparam int DUTY_LSB   = FREQ_LSB + FREQ_W;

    typedef struct packed {
        logic [WIDTH_W-1:0] high;
        logic [WIDTH_W-1:0] low;
        logic [WIDTH_W-1:0] period;
        logic [FREQ_W-1:0]  freq;
        logic [DUTY_W-1:0]  duty;
        logic               valid;
    } meter_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [CAP_DATA_W-1:0] s_tdata = '0;   // [15:0] capture_count
    logic                  s_tuser = 1'b0; // [0] pin_read
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // high, low, period, freq, duty, zero fill
    logic                  m_tuser;        // [0] period_valid
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data = '0;

    // meter state as the block should hold it
    logic [CFG_W-1:0]   count_freq_hz = COUNT_FREQ_RESET;
    logic [WIDTH_W-1:0] last_edge = '0;
    logic [WIDTH_W-1:0] high_w = '0;
    logic [WIDTH_W-1:0] low_w = '0;
    logic [FREQ_W-1:0]  freq_q = '0;
    logic [DUTY_W-1:0]  duty_q = '0;

    meter_word_t    meter_words_due[$];
    logic [CAP_W-1:0] timer_now = '0;   // last capture sent
    int             fail_count = 0;
    int             quiet_cycles = 0;
    int             tx_idle_pct = 0;
    int             rx_stall_pct = 0;

    always #6 clk = ~clk;

    pulse_width_duty_meter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Advance the meter by one capture event and return the word it should emit.
    // Width goes to low when the pin reads 0, to high otherwise; ratios are
    // refreshed only for a nonzero period, else the stored ones repeat.
    function automatic meter_word_t meter_update(input logic [CAP_W-1:0] cap,
                                                 input logic pin);
        logic [WIDTH_W-1:0] cur;
        logic [WIDTH_W-1:0] diff;
        logic [WIDTH_W-1:0] period;
        logic [63:0]        freq_full;
        logic [63:0]        duty_full;
        meter_word_t        w;
        cur = WIDTH_W'(cap);
        cur = cur + 1'b1;   // sync latency
        diff = cur - last_edge;
        if (pin)
            high_w = diff;
        else
            low_w = diff;
        period = high_w + low_w;
        if (period != '0)
        begin
            freq_full = 64'(count_freq_hz) << FRAC_BITS;
            freq_full = freq_full / 64'(period);
            duty_full = (64'(high_w) * 64'(DUTY_FULL)) / 64'(period);
            if (duty_full > 64'(DUTY_FULL))
                duty_full = 64'(DUTY_FULL);
            freq_q = freq_full[FREQ_W-1:0];
            duty_q = duty_full[DUTY_W-1:0];
        end
        last_edge = cur;
        w.high   = high_w;
        w.low    = low_w;
        w.period = period;
        w.freq   = freq_q;
        w.duty   = duty_q;
        w.valid  = (period != '0);
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // One capture word; sender gaps are rolled before the word is offered.
    task automatic send_capture(input logic [CAP_W-1:0] cap, input logic pin);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cap;
        s_tuser  <= pin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        meter_words_due.push_back(meter_update(cap, pin));
        timer_now = cap;
    endtask

    // Stop sending, let every due word arrive, then give the back end time
    // to finish anything still running.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (meter_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count_freq(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        count_freq_hz = value;
    endtask

    function automatic int pick_width();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 8);
            1:       return $urandom_range(9, 500);
            2:       return $urandom_range(501, 20000);
            default: return $urandom_range(20001, 65535);
        endcase
    endfunction

    // Reset state and the default count frequency.
    task automatic test_after_reset();
        send_capture('0, 1'b0);          // low = 1: shortest period, top frequency
        send_capture('1, 1'b1);          // largest capture
        send_capture('1, 1'b0);          // repeated capture: low = 0, duty exactly full
    endtask

    // Wrapping differences and the cases they open up.
    task automatic test_width_wrap();
        send_capture(16'd100, 1'b1);     // capture goes backward, high wraps
        send_capture('1, 1'b0);          // low cancels high: zero period, ratios held
        send_capture('1, 1'b1);          // high = 0 after a zero period
        send_capture('0, 1'b0);
        send_capture('1, 1'b0);          // low = max forward step
        send_capture(16'd9, 1'b1);       // big negative high, period 9: high above period
        send_capture(16'd9, 1'b1);       // high = 0, duty 0
        send_capture(16'h5555, 1'b1);
        send_capture(16'hAAAA, 1'b0);
        send_capture(16'h8000, 1'b1);
        send_capture(16'h7FFF, 1'b0);
    endtask

    // Count frequency at its top, at one and at zero, each with a one-count period.
    task automatic test_count_freq_extremes();
        write_count_freq(COUNT_FREQ_MAX);
        send_capture(timer_now, 1'b1);
        send_capture(timer_now + 1'b1, 1'b0);
        write_count_freq(24'd1);
        send_capture(timer_now, 1'b1);
        send_capture(timer_now + 1'b1, 1'b0);
        write_count_freq('0);
        send_capture(timer_now, 1'b1);
        send_capture(timer_now + 1'b1, 1'b0);
    endtask

    // Mostly alternating-pin bursts of a steady signal with jitter, plus noise.
    task automatic test_random_phases();
        int               sent;
        int               hi;
        int               lo;
        int               burst;
        int               width;
        logic             pin;
        logic [CFG_W-1:0] freq;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       freq = COUNT_FREQ_MAX;
                1:       freq = CFG_W'($urandom_range(2, COUNT_FREQ_MAX - 1));
                2:       freq = 24'd1;
                default: freq = CFG_W'($urandom_range(1, COUNT_FREQ_MAX));
            endcase
            write_count_freq(freq);
            case (phase)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 76; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 76; end
                default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    hi    = pick_width();
                    lo    = pick_width();
                    burst = $urandom_range(2, 16);
                    pin   = 1'($urandom_range(0, 1));
                    for (int k = 0; k < burst; k++)
                    begin
                        // pin 1 after the edge closes a high interval
                        width = (pin ? hi : lo) + $urandom_range(0, 2);
                        send_capture(CAP_W'(timer_now + width), pin);
                        pin = ~pin;
                        sent++;
                    end
                end
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_capture(timer_now, 1'($urandom_range(0, 1)));
                    else
                        send_capture(CAP_W'($urandom_range(0, (1 << CAP_W) - 1)),
                                     1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
    endtask

    // Result checker, receiver stalls and the quiet-cycle count.
    always @(posedge clk)
    begin : word_check
        meter_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (meter_words_due.size() == 0)
                flag_mismatch("word with nothing due", 64'(m_tdata[HIGH_LSB +: WIDTH_W]), '0);
            else
            begin
                want = meter_words_due.pop_front();
                if (m_tdata[HIGH_LSB +: WIDTH_W] !== want.high)
                    flag_mismatch("high_len", 64'(m_tdata[HIGH_LSB +: WIDTH_W]), 64'(want.high));
                if (m_tdata[LOW_LSB +: WIDTH_W] !== want.low)
                    flag_mismatch("low_len", 64'(m_tdata[LOW_LSB +: WIDTH_W]), 64'(want.low));
                if (m_tdata[PERIOD_LSB +: WIDTH_W] !== want.period)
                    flag_mismatch("period_counts", 64'(m_tdata[PERIOD_LSB +: WIDTH_W]),
                                  64'(want.period));
                if (m_tdata[FREQ_LSB +: FREQ_W] !== want.freq)
                    flag_mismatch("frequency_q16", 64'(m_tdata[FREQ_LSB +: FREQ_W]),
                                  64'(want.freq));
                if (m_tdata[DUTY_LSB +: DUTY_W] !== want.duty)
                    flag_mismatch("duty_q8", 64'(m_tdata[DUTY_LSB +: DUTY_W]), 64'(want.duty));
                if (m_tuser !== want.valid)
                    flag_mismatch("period_valid", 64'(m_tuser), 64'(want.valid));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_width_wrap();
        test_count_freq_extremes();
        test_random_phases();
        drain_results();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
design/pwdm_pkg.sv
design/pwdm_front.sv
design/pwdm_fifo.sv
design/pwdm_back.sv
design/pulse_width_duty_meter.sv
design/pwdm_checker.sv
bench/tb_pulse_width_duty_meter.sv
